FILE: hw/rtl/command_slot_tracker_macros.svh
// ----------------------------------------------------------------------------
// command_slot_tracker_macros.svh
// Assertion macros shared by the command slot tracker RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_SLOT_TRACKER_MACROS_SVH
`define COMMAND_SLOT_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Types and constants of the command slot tracker.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int SLOTS = 32;
	localparam logic [31:0] SLOT_MASK = 32'((64'd1 << SLOTS) - 64'd1);

	localparam logic [1:0] MODE_ALLOC    = 2'd0;
	localparam logic [1:0] MODE_RELEASE  = 2'd1;
	localparam logic [1:0] MODE_SUBMIT   = 2'd2;
	localparam logic [1:0] MODE_COMPLETE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  slot;
		logic [31:0] issue_bits;
		logic [31:0] active_bits;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  granted_slot;
		logic [31:0] freed_mask;
		logic [5:0]  freed_count;
		logic [31:0] issued_now;
	} result_t;

endpackage

FILE: hw/rtl/command_slot_tracker.sv
// ----------------------------------------------------------------------------
// command_slot_tracker
// Used and issue mask bookkeeping for the command slots of a storage port.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a command word on cmd and pulse start. busy stays low, so a word
//   is taken at every edge with start high, one word per cycle sustained.
//   Modes: allocate the lowest free slot, release a slot, submit a slot, or
//   process completions from the sampled device issue and active masks.
//   Each word goes into an input register; the next cycle computes the
//   answer and the new masks in one pass and loads the result register.
//   done is registered from the input register's valid bit at the edge that
//   loads the result register, and stays high for exactly one cycle with the
//   result word; the receiver cannot hold it off.
//   Back-to-back words see each other's mask updates in order, since the
//   masks change at the same edge that loads the result register.
//   Reset clears both masks and all pending strobes.
// ----------------------------------------------------------------------------
`include "command_slot_tracker_macros.svh"

module command_slot_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cst_pkg::cmd_t      cmd,
	output logic               done,
	output cst_pkg::result_t   result
);

	logic             valid_s1;
	cst_pkg::cmd_t    cmd_s1;
	logic [31:0]      used_q;
	logic [31:0]      issue_q;
	logic             done_q;
	cst_pkg::result_t result_q;

	logic [31:0]      used_d;
	logic [31:0]      issue_d;
	cst_pkg::result_t res_d;
	logic [31:0]      free_bits;
	logic [4:0]       first_free;
	logic [31:0]      dev_issue;
	logic [31:0]      dev_active;
	logic [31:0]      freed;
	logic [5:0]       freed_n;
	logic             slot_bad;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	// lowest free slot
	always_comb begin
		free_bits  = ~used_q & cst_pkg::SLOT_MASK;
		first_free = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (free_bits[i]) begin
				first_free = 5'(i);
			end
		end
	end

	always_comb begin
		dev_issue  = cmd_s1.issue_bits & cst_pkg::SLOT_MASK;
		dev_active = cmd_s1.active_bits & cst_pkg::SLOT_MASK;
		freed      = used_q & ~(dev_issue | dev_active);
		freed_n    = 6'd0;
		for (int i = 0; i < 32; i++) begin
			freed_n = freed_n + 6'(freed[i]);
		end
	end

	assign slot_bad = ({1'b0, cmd_s1.slot} >= 7'(cst_pkg::SLOTS));

	always_comb begin
		used_d             = used_q;
		issue_d            = issue_q;
		res_d.status       = cst_pkg::ST_OK;
		res_d.granted_slot = 5'd0;
		res_d.freed_mask   = 32'd0;
		res_d.freed_count  = 6'd0;
		case (cmd_s1.mode)
			cst_pkg::MODE_ALLOC: begin
				if (free_bits == 32'd0) begin
					res_d.status = cst_pkg::ST_FULL;
				end else begin
					res_d.granted_slot = first_free;
					used_d[first_free] = 1'b1;
				end
			end
			cst_pkg::MODE_RELEASE: begin
				if (slot_bad) begin
					res_d.status = cst_pkg::ST_BAD_SLOT;
				end else begin
					used_d[cmd_s1.slot[4:0]] = 1'b0;
				end
			end
			cst_pkg::MODE_SUBMIT: begin
				if (slot_bad) begin
					res_d.status = cst_pkg::ST_BAD_SLOT;
				end else begin
					issue_d[cmd_s1.slot[4:0]] = 1'b1;
				end
			end
			cst_pkg::MODE_COMPLETE: begin
				issue_d           = dev_issue;
				used_d            = used_q & ~freed;
				res_d.freed_mask  = freed;
				res_d.freed_count = freed_n;
			end
			default: begin
				res_d.status = cst_pkg::ST_OK;
			end
		endcase
		res_d.issued_now = issue_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 32'd0;
			issue_q <= 32'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				used_q  <= used_d;
				issue_q <= issue_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	`CST_ASSERT_NOW(a_count_matches, done, result.freed_count == 6'($countones(result.freed_mask)), "freed count disagrees with freed mask")
	`CST_ASSERT_NOW(a_freed_cleared, done, (used_q & result.freed_mask) == 32'd0, "freed slot still marked used")
	`CST_ASSERT_NOW(a_issue_mirror, done, result.issued_now == issue_q, "reported issue mask differs from state")
	`CST_ASSERT_NEXT(a_grant_claimed, valid_s1 && cmd_s1.mode == cst_pkg::MODE_ALLOC && free_bits != 32'd0, used_q[result.granted_slot] && !$past(used_q[first_free]), "granted slot not claimed")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for command_slot_tracker: a slot ledger mirrors the
// used and issue masks, predicts the answer to every accepted command word
// and checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	class slot_ledger;
		logic [31:0]      used_mask;
		logic [31:0]      issue_mask;
		cst_pkg::result_t pending_answers[$];
		int               mismatches;

		function new();
			used_mask  = '0;
			issue_mask = '0;
			mismatches = 0;
		endfunction

		// Advance the masks by one accepted word and queue its answer.
		function void note_word(cst_pkg::cmd_t w);
			cst_pkg::result_t r;
			logic [31:0]      free_bits;
			logic [31:0]      dev_issue;
			logic [31:0]      dev_active;
			r          = '0;
			dev_issue  = w.issue_bits & cst_pkg::SLOT_MASK;
			dev_active = w.active_bits & cst_pkg::SLOT_MASK;
			case (w.mode)
				cst_pkg::MODE_ALLOC: begin
					free_bits = ~used_mask & cst_pkg::SLOT_MASK;
					if (free_bits == '0) begin
						r.status = cst_pkg::ST_FULL;
					end else begin
						for (int i = cst_pkg::SLOTS - 1; i >= 0; i--)
							if (free_bits[i]) r.granted_slot = 5'(i);
						used_mask[r.granted_slot] = 1'b1;
					end
				end
				cst_pkg::MODE_RELEASE, cst_pkg::MODE_SUBMIT: begin
					if (w.slot >= cst_pkg::SLOTS) begin
						r.status = cst_pkg::ST_BAD_SLOT;
					end else if (w.mode == cst_pkg::MODE_RELEASE) begin
						used_mask[w.slot[4:0]] = 1'b0;
					end else begin
						issue_mask[w.slot[4:0]] = 1'b1;
					end
				end
				default: begin
					issue_mask    = dev_issue;
					r.freed_mask  = used_mask & ~(dev_issue | dev_active) & cst_pkg::SLOT_MASK;
					used_mask     = used_mask & ~r.freed_mask;
					r.freed_count = 6'($countones(r.freed_mask));
				end
			endcase
			r.issued_now = issue_mask;
			pending_answers.push_back(r);
		endfunction

		function void check_answer(cst_pkg::result_t got);
			cst_pkg::result_t want;
			if (pending_answers.size() == 0) begin
				$error("result with no word outstanding: %p", got);
				mismatches++;
				return;
			end
			want = pending_answers.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.granted_slot !== want.granted_slot) begin
				$error("granted_slot: expected %0d, got %0d",
					want.granted_slot, got.granted_slot);
				mismatches++;
			end
			if (got.freed_mask !== want.freed_mask) begin
				$error("freed_mask: expected %h, got %h", want.freed_mask, got.freed_mask);
				mismatches++;
			end
			if (got.freed_count !== want.freed_count) begin
				$error("freed_count: expected %0d, got %0d",
					want.freed_count, got.freed_count);
				mismatches++;
			end
			if (got.issued_now !== want.issued_now) begin
				$error("issued_now: expected %h, got %h", want.issued_now, got.issued_now);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	cst_pkg::cmd_t    cmd    = '0;
	logic             busy;
	logic             done;
	cst_pkg::result_t result;

	slot_ledger ledger;
	int         words_sent;
	int         quiet_left;

	always #5 clk = ~clk;

	command_slot_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Outputs are read at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) ledger.check_answer(result);
	end

	function automatic cst_pkg::cmd_t noise_word();
		cst_pkg::cmd_t w;
		w.mode        = 2'($urandom);
		w.slot        = 6'($urandom);
		w.issue_bits  = $urandom;
		w.active_bits = $urandom;
		return w;
	endfunction

	function automatic cst_pkg::cmd_t make_word(logic [1:0] mode, logic [5:0] slot,
			logic [31:0] iss, logic [31:0] act);
		cst_pkg::cmd_t w;
		w.mode        = mode;
		w.slot        = slot;
		w.issue_bits  = iss;
		w.active_bits = act;
		return w;
	endfunction

	// Pick a random set bit of mask, or any slot number when mask is empty.
	function automatic logic [5:0] pick_slot(logic [31:0] mask);
		int k;
		if (mask == '0) return 6'($urandom_range(0, 63));
		k = $urandom_range(0, $countones(mask) - 1);
		for (int i = 0; i < 32; i++) begin
			if (mask[i]) begin
				if (k == 0) return 6'(i);
				k--;
			end
		end
		return 6'd0;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input cst_pkg::cmd_t w);
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy !== 1'b0);
		ledger.note_word(w);
	endtask

	task automatic pause_for(input int n);
		start <= 1'b0;
		cmd   <= noise_word();
		repeat (n) @(posedge clk);
	endtask

	// Hold the sender until every predicted answer has come back.
	task automatic settle();
		start <= 1'b0;
		while (ledger.pending_answers.size() != 0) @(posedge clk);
	endtask

	task automatic feed(input cst_pkg::cmd_t w);
		int gap;
		send_word(w);
		words_sent++;
		if (quiet_left > 0) begin
			quiet_left--;
		end else begin
			gap = gap_len();
			if (gap > 0) pause_for(gap);
		end
	endtask

	initial begin
		int            k;
		cst_pkg::cmd_t w;
		ledger     = new();
		words_sent = 0;
		quiet_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slot and mask fields are ignored on allocate
		send_word(make_word(cst_pkg::MODE_ALLOC, 6'd63, '1, '1));
		send_word(make_word(cst_pkg::MODE_ALLOC, 6'd0, '0, '0));
		send_word(make_word(cst_pkg::MODE_ALLOC, 6'd21, 32'h5555_aaaa, 32'haaaa_5555));
		send_word(make_word(cst_pkg::MODE_RELEASE, 6'd1, '1, '1));
		send_word(make_word(cst_pkg::MODE_ALLOC, 6'd0, '0, '0));
		send_word(make_word(cst_pkg::MODE_SUBMIT, 6'd0, '0, '0));
		// unclaimed, then already issued
		send_word(make_word(cst_pkg::MODE_SUBMIT, 6'd31, '0, '0));
		send_word(make_word(cst_pkg::MODE_SUBMIT, 6'd31, '1, '0));
		// first out-of-range slot numbers and the largest one
		send_word(make_word(cst_pkg::MODE_SUBMIT, 6'd32, '0, '0));
		send_word(make_word(cst_pkg::MODE_RELEASE, 6'd63, '0, '0));
		send_word(make_word(cst_pkg::MODE_RELEASE, 6'd32, '0, '0));
		send_word(make_word(cst_pkg::MODE_RELEASE, 6'd20, '0, '0));
		send_word(make_word(cst_pkg::MODE_COMPLETE, 6'd63, 32'h8000_0001, 32'h0000_0004));
		send_word(make_word(cst_pkg::MODE_COMPLETE, 6'd0, '1, '1));
		send_word(make_word(cst_pkg::MODE_COMPLETE, 6'd0, '0, '0));
		send_word(make_word(cst_pkg::MODE_COMPLETE, 6'd17, 32'hdead_beef, 32'h1234_5678));
		settle();

		while (words_sent < 1000) begin
			if (quiet_left == 0 && $urandom_range(0, 19) == 0)
				quiet_left = $urandom_range(10, 40);
			k = $urandom_range(0, 99);
			if (k < 3) begin
				// fill every slot, then ask for more
				while (ledger.used_mask != cst_pkg::SLOT_MASK) begin
					w      = noise_word();
					w.mode = cst_pkg::MODE_ALLOC;
					feed(w);
				end
				repeat ($urandom_range(1, 3)) begin
					w      = noise_word();
					w.mode = cst_pkg::MODE_ALLOC;
					feed(w);
				end
			end else if (k < 5) begin
				settle();
			end else if (k < 35) begin
				w      = noise_word();
				w.mode = cst_pkg::MODE_ALLOC;
				feed(w);
			end else if (k < 50) begin
				w      = noise_word();
				w.mode = cst_pkg::MODE_RELEASE;
				if ($urandom_range(0, 4) != 0) w.slot = pick_slot(ledger.used_mask);
				feed(w);
			end else if (k < 70) begin
				w      = noise_word();
				w.mode = cst_pkg::MODE_SUBMIT;
				if ($urandom_range(0, 4) != 0)
					w.slot = pick_slot(ledger.used_mask & ~ledger.issue_mask);
				feed(w);
			end else if (k < 90) begin
				w      = noise_word();
				w.mode = cst_pkg::MODE_COMPLETE;
				// device retires some issued slots and keeps some active
				if ($urandom_range(0, 3) != 0) begin
					w.issue_bits  = ledger.issue_mask & $urandom;
					w.active_bits = ledger.used_mask & $urandom & $urandom;
				end
				feed(w);
			end else begin
				feed(noise_word());
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending_answers.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
